>>> rtl/bpe_pkg.sv
// shared types, event codes and register constants for the button press event classifier
// no dependencies
package bpe_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int NUM_BUTTONS    = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_INDEX_W    = 2;
  localparam int INTERVAL_W     = 10;
  localparam int DURATION_W     = 16;

  localparam logic [INTERVAL_W-1:0] UPDATE_INTERVAL_RST = INTERVAL_W'(25);
  localparam logic [DURATION_W-1:0] LONG_PRESS_RST      = DURATION_W'(400);
  localparam logic [DURATION_W-1:0] DOUBLE_PRESS_RST    = DURATION_W'(400);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_UPDATE_INTERVAL = 2'd0,
    CFG_LONG_PRESS      = 2'd1,
    CFG_DOUBLE_PRESS    = 2'd2
  } bpe_cfg_idx_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_STEADY_REL = 3'd1,
    EV_STEADY_PRS = 3'd2,
    EV_PRESSED    = 3'd3,
    EV_RELEASED   = 3'd4,
    EV_LONG       = 3'd5,
    EV_DOUBLE     = 3'd6,
    EV_SINGLE     = 3'd7
  } bpe_event_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        push_pin;
    logic        pull_pin;
    logic        cfg_pin;
  } bpe_in_t;

  typedef struct packed {
    logic       updated;
    logic [2:0] push_event;
    logic [2:0] pull_event;
    logic [2:0] cfg_event;
  } bpe_out_t;

  typedef struct packed {
    logic [DURATION_W-1:0] long_press_ms;
    logic [DURATION_W-1:0] double_press_ms;
  } bpe_lane_cfg_t;

endpackage

>>> rtl/button_press_event_classifier.sv
// top level: rate gate, three classifier lanes, merge into one result beat, output skid
// depends on bpe_pkg and bpe_lane
// a result beat is registered in out_r, or in skid_r while out_r holds a stalled beat
// throughput: one beat per cycle while in_stall is low, i.e. while the skid is empty
// the two-entry output buffer keeps input open while one result waits
// reset (rst_n low, synchronous): registers to defaults, all buttons pressed, times zero
module button_press_event_classifier #(
  parameter int TIME_WIDTH = bpe_pkg::TIME_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  bpe_pkg::bpe_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output bpe_pkg::bpe_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [bpe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bpe_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bpe_pkg::*;

  logic [INTERVAL_W-1:0] interval_r;
  bpe_lane_cfg_t         lane_cfg_r;
  logic [TIME_WIDTH-1:0] last_eval_r;
  logic [TIME_WIDTH-1:0] now, earliest;
  logic                  too_soon, in_fire, out_fire, eval;
  logic [NUM_BUTTONS-1:0] pins;
  bpe_event_t            lane_ev [NUM_BUTTONS];
  bpe_out_t              result;
  logic                  out_valid_r, skid_valid_r;
  bpe_out_t              out_r, skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r                 <= UPDATE_INTERVAL_RST;
      lane_cfg_r.long_press_ms   <= LONG_PRESS_RST;
      lane_cfg_r.double_press_ms <= DOUBLE_PRESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UPDATE_INTERVAL: interval_r <= cfg_wdata[INTERVAL_W-1:0];
        CFG_LONG_PRESS:      lane_cfg_r.long_press_ms <= cfg_wdata[DURATION_W-1:0];
        CFG_DOUBLE_PRESS:    lane_cfg_r.double_press_ms <= cfg_wdata[DURATION_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign now      = TIME_WIDTH'(in_data.now_ms);
  assign earliest = last_eval_r + TIME_WIDTH'(interval_r);
  assign too_soon = now < earliest;
  assign eval     = in_fire && !too_soon;
  assign pins     = {in_data.cfg_pin, in_data.pull_pin, in_data.push_pin};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_eval_r <= '0;
    end else if (eval) begin
      last_eval_r <= now;
    end
  end

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    bpe_lane #(
      .TIME_WIDTH(TIME_WIDTH)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .upd      (eval),
      .now      (now),
      .pin      (pins[b]),
      .lane_cfg (lane_cfg_r),
      .ev       (lane_ev[b])
    );
  end

  // merge lane findings into one result beat
  always_comb begin
    result.updated    = !too_soon;
    result.push_event = too_soon ? EV_NONE : lane_ev[0];
    result.pull_event = too_soon ? EV_NONE : lane_ev[1];
    result.cfg_event  = too_soon ? EV_NONE : lane_ev[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_fire) begin
        skid_valid_r <= 1'b1;
      end
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_fire) begin
        skid_r <= result;
      end else begin
        out_r <= result;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while output register is empty");

  a_skip_no_events: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.updated |->
      out_r.push_event == EV_NONE && out_r.pull_event == EV_NONE &&
      out_r.cfg_event == EV_NONE)
    else $error("skipped sample carries an event");

  a_eval_has_events: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.updated |->
      out_r.push_event != EV_NONE && out_r.pull_event != EV_NONE &&
      out_r.cfg_event != EV_NONE)
    else $error("evaluated sample lacks an event");

  a_eval_time: assert property (@(posedge clk) disable iff (!rst_n)
    eval |=> last_eval_r == $past(now))
    else $error("last evaluation time not captured");

  a_skip_holds_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && too_soon |=> $stable(last_eval_r))
    else $error("skipped sample moved last evaluation time");

endmodule

>>> rtl/bpe_lane.sv
// per-button classifier lane: level, change, release and single deadline state
// depends on bpe_pkg
module bpe_lane #(
  parameter int TIME_WIDTH = bpe_pkg::TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  upd,
  input  logic [TIME_WIDTH-1:0] now,
  input  logic                  pin,
  input  bpe_pkg::bpe_lane_cfg_t lane_cfg,
  output bpe_pkg::bpe_event_t   ev
);
  import bpe_pkg::*;

  logic                  pressed_r, pressed_nxt;
  logic [TIME_WIDTH-1:0] chg_r, chg_nxt;
  logic [TIME_WIDTH-1:0] rel_r, rel_nxt;
  logic [TIME_WIDTH-1:0] dl_r, dl_nxt;
  logic [TIME_WIDTH-1:0] held, rel_to_rel, long_t, dbl_t;

  assign long_t     = TIME_WIDTH'(lane_cfg.long_press_ms);
  assign dbl_t      = TIME_WIDTH'(lane_cfg.double_press_ms);
  assign held       = now - chg_r;
  assign rel_to_rel = now - rel_r;

  always_comb begin
    pressed_nxt = pressed_r;
    chg_nxt     = chg_r;
    rel_nxt     = rel_r;
    dl_nxt      = dl_r;
    ev          = EV_STEADY_PRS;
    if (pin) begin
      if (pressed_r) begin
        pressed_nxt = 1'b0;
        rel_nxt     = now;
        chg_nxt     = now;
        if (held > long_t) begin
          dl_nxt = '0;
          ev     = EV_LONG;
        end else if (rel_to_rel < dbl_t) begin
          dl_nxt = '0;
          ev     = EV_DOUBLE;
        end else begin
          dl_nxt = now + dbl_t;
          ev     = EV_RELEASED;
        end
      end else if (dl_r != '0 && now > dl_r) begin
        dl_nxt = '0;
        ev     = EV_SINGLE;
      end else begin
        ev = EV_STEADY_REL;
      end
    end else if (!pressed_r) begin
      pressed_nxt = 1'b1;
      chg_nxt     = now;
      ev          = EV_PRESSED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= 1'b1;
      chg_r     <= '0;
      rel_r     <= '0;
      dl_r      <= '0;
    end else if (upd) begin
      pressed_r <= pressed_nxt;
      chg_r     <= chg_nxt;
      rel_r     <= rel_nxt;
      dl_r      <= dl_nxt;
    end
  end

endmodule
